// File: rtl/core/lgpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lgpg_pkg;

  localparam int MAX_STOPS_DEF  = 16;
  localparam int COORD_BITS_DEF = 12;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DIR_X        = 3'd2;
  localparam logic [2:0] REG_DIR_Y        = 3'd3;
  localparam logic [2:0] REG_STOP_COUNT   = 3'd4;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam int Q_BITS = 16;
  localparam logic [16:0] Q16_ONE = 17'h10000;

  typedef enum logic [1:0] {
    MODE_WHITE,
    MODE_SOLID,
    MODE_BLEND
  } mode_t;

  // Side band that travels with every word down the pipeline
  typedef struct packed {
    logic        pix;
    mode_t       mode;
    logic [4:0]  cnt;
    logic        len0;
    logic [3:0]  slot;
    logic [31:0] rgba;
    logic [25:0] off;
  } side_t;

  // Truncating lerp of one byte, f in 0..65536
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [16:0] f);
    logic [24:0] s;
    s = 25'(a) * 25'(Q16_ONE - f) + 25'(b) * 25'(f);
    return s[23:16];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lgpg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lgpg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/linear_gradient_pixel_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Linear gradient fill engine.
// Input channel (in_valid / in_stall): each word is either a stop load
// (req_type 0: stop_rgba goes to table entry stop_slot) or a pixel request
// (req_type 1: pixel_x, pixel_y). Only pixel words produce an output word.
// Output channel (out_valid / out_stall): B, G, R, A bytes of the pixel and
// its byte offset in a BGRA buffer, in request order.
// Throughput: one word per clock while the receiver does not stall. The pipeline
// holds the multiply stages, the 16-stage restoring divider that forms the
// Q0.16 quotient of the position, and the registered read of the stop table.
// Loads travel the same pipeline and write the table in order with the pixel
// reads, so a pixel sees exactly the stops loaded before it.
// When the receiver stalls, the output word holds; earlier stages keep
// filling empty slots, and in_stall rises only once no slot is free.
// Reset empties the pipeline and loads the register defaults (256 x 256,
// direction +x, two stops). The stop table is not cleared: load every stop
// in use before requesting pixels. Write configuration only while idle.
module linear_gradient_pixel_generator_unit #(
  parameter int MAX_STOPS  = lgpg_pkg::MAX_STOPS_DEF,
  parameter int COORD_BITS = lgpg_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [4:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  req_type,
  input  wire logic [COORD_BITS-1:0] pixel_x,
  input  wire logic [COORD_BITS-1:0] pixel_y,
  input  wire logic [3:0]            stop_slot,
  input  wire logic [31:0]           stop_rgba,
  // pixel channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [7:0]            out_blue,
  output logic      [7:0]            out_green,
  output logic      [7:0]            out_red,
  output logic      [7:0]            out_alpha,
  output logic      [25:0]           byte_offset
);

  import lgpg_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int ADDR_W = $clog2(MAX_STOPS);
  // num = 2*(x*dx*h + y*dy*w) + L*w*h; L*w*h < 2^43
  localparam int NUM_W  = ((CW + 31 > 44) ? CW + 31 : 44) + 1;

  // Pipeline stage numbers
  localparam int ST_MUL1 = 1;
  localparam int ST_MUL2 = 2;
  localparam int ST_SUM  = 3;
  localparam int ST_CMP  = 4;
  localparam int ST_DIV0 = ST_CMP + 1;
  localparam int ST_DIVN = ST_CMP + Q_BITS;
  localparam int ST_POS  = ST_DIVN + 1;
  localparam int ST_SCL  = ST_POS + 1;
  localparam int ST_RAM  = ST_SCL + 1;
  localparam int NSTG    = ST_RAM + 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [12:0]        image_width;
  logic [12:0]        image_height;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic [4:0]         stop_count;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd256;
      image_height <= 13'd256;
      dir_x        <= 16'sd16384;
      dir_y        <= 16'sd0;
      stop_count   <= 5'd2;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[12:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[12:0];
        REG_DIR_X:        dir_x        <= $signed(pwdata[15:0]);
        REG_DIR_Y:        dir_y        <= $signed(pwdata[15:0]);
        REG_STOP_COUNT:   stop_count   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      REG_DIR_X:        prdata = 32'($unsigned(dir_x));
      REG_DIR_Y:        prdata = 32'($unsigned(dir_y));
      REG_STOP_COUNT:   prdata = 32'(stop_count);
      default:          prdata = 32'd0;
    endcase
  end

  // Derived configuration: zero size reads as one, count saturates
  logic [12:0]        w_eff;
  logic [12:0]        h_eff;
  logic signed [16:0] dxe;
  logic signed [16:0] dye;
  logic [16:0]        dx_mag;
  logic [16:0]        dy_mag;
  logic [16:0]        l_len;
  logic [4:0]         n_sat;
  mode_t              mode_cfg;

  always_comb begin
    w_eff  = (image_width == 13'd0) ? 13'd1 : image_width;
    h_eff  = (image_height == 13'd0) ? 13'd1 : image_height;
    dxe    = {dir_x[15], dir_x};
    dye    = {dir_y[15], dir_y};
    dx_mag = dxe[16] ? 17'($unsigned(-dxe)) : 17'($unsigned(dxe));
    dy_mag = dye[16] ? 17'($unsigned(-dye)) : 17'($unsigned(dye));
    l_len  = dx_mag + dy_mag;
    n_sat  = (32'(stop_count) > MAX_STOPS) ? 5'(MAX_STOPS) : stop_count;
    case (n_sat)
      5'd0:    mode_cfg = MODE_WHITE;
      5'd1:    mode_cfg = MODE_SOLID;
      default: mode_cfg = MODE_BLEND;
    endcase
  end

  // Side band storage, declared ahead of the flow control that reads it
  side_t side [ST_MUL1:ST_SCL];
  side_t side_in;
  side_t side_m2;
  logic [25:0] off_next;

  // ---------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its successor loads
  // ---------------------------------------------------------------------
  logic [NSTG:1] v;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !v[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k + 1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          if (k == ST_RAM) begin
            // loads retire at the table write
            v[k] <= v[ST_SCL] && side[ST_SCL].pix;
          end else begin
            v[k] <= v[k - 1];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Side band
  // ---------------------------------------------------------------------
  always_comb begin
    side_in.pix  = (req_type == REQ_PIXEL);
    side_in.mode = mode_cfg;
    side_in.cnt  = n_sat;
    side_in.len0 = (l_len == 17'd0);
    side_in.slot = stop_slot;
    side_in.rgba = stop_rgba;
    side_in.off  = '0;
  end

  // Attach the byte offset once the row product is ready
  always_comb begin
    side_m2     = side[ST_MUL1];
    side_m2.off = off_next;
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL1]) begin
      side[ST_MUL1] <= side_in;
    end
    if (en[ST_MUL2]) begin
      side[ST_MUL2] <= side_m2;
    end
    for (int k = ST_SUM; k <= ST_SCL; k++) begin
      if (en[k]) begin
        side[k] <= side[k - 1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Projection: x*dx*h + y*dy*w against L*w*h
  // ---------------------------------------------------------------------
  logic signed [CW+16:0] xdx1;
  logic signed [CW+16:0] ydy1;
  logic [29:0]           lw1;
  logic [CW+12:0]        yw1;
  logic [CW-1:0]         x1;

  always_ff @(posedge clk) begin
    if (en[ST_MUL1]) begin
      xdx1 <= $signed({1'b0, pixel_x}) * dir_x;
      ydy1 <= $signed({1'b0, pixel_y}) * dir_y;
      lw1  <= 30'(l_len) * 30'(w_eff);
      yw1  <= (CW+13)'(pixel_y) * (CW+13)'(w_eff);
      x1   <= pixel_x;
    end
  end

  logic signed [CW+30:0] a2;
  logic signed [CW+30:0] b2;
  logic [42:0]           lwh2;

  assign off_next = 26'({24'(yw1 + (CW+13)'(x1)), 2'b00});

  always_ff @(posedge clk) begin
    if (en[ST_MUL2]) begin
      a2   <= xdx1 * $signed({1'b0, h_eff});
      b2   <= ydy1 * $signed({1'b0, w_eff});
      lwh2 <= 43'(lw1) * 43'(h_eff);
    end
  end

  logic signed [NUM_W-1:0] sum_ab;
  logic signed [NUM_W-1:0] num_next;
  logic signed [NUM_W-1:0] num3;
  logic [43:0]             den3;

  always_comb begin
    sum_ab   = NUM_W'(a2) + NUM_W'(b2);
    num_next = $signed({sum_ab[NUM_W-2:0], 1'b0}) + $signed(NUM_W'(lwh2));
  end

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      num3 <= num_next;
      den3 <= {lwh2, 1'b0};
    end
  end

  // ---------------------------------------------------------------------
  // Clamp detection and restoring divider, one quotient bit a stage
  // ---------------------------------------------------------------------
  logic [43:0]       rem  [ST_CMP:ST_DIVN];
  logic [43:0]       den  [ST_CMP:ST_DIVN];
  logic [Q_BITS-1:0] quo  [ST_CMP:ST_DIVN];
  logic              zero [ST_CMP:ST_DIVN];
  logic              one  [ST_CMP:ST_DIVN];
  logic [44:0]       r2   [ST_DIV0:ST_DIVN];
  logic              ge   [ST_DIV0:ST_DIVN];

  always_comb begin
    for (int k = ST_DIV0; k <= ST_DIVN; k++) begin
      r2[k] = {rem[k - 1], 1'b0};
      ge[k] = r2[k] >= {1'b0, den[k - 1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_CMP]) begin
      rem[ST_CMP]  <= num3[43:0];
      den[ST_CMP]  <= den3;
      quo[ST_CMP]  <= '0;
      zero[ST_CMP] <= side[ST_SUM].len0 || (num3 <= 0);
      one[ST_CMP]  <= num3 >= $signed(NUM_W'(den3));
    end
    for (int k = ST_DIV0; k <= ST_DIVN; k++) begin
      if (en[k]) begin
        rem[k]  <= ge[k] ? 44'(r2[k] - {1'b0, den[k - 1]}) : r2[k][43:0];
        den[k]  <= den[k - 1];
        quo[k]  <= {quo[k - 1][Q_BITS-2:0], ge[k]};
        zero[k] <= zero[k - 1];
        one[k]  <= one[k - 1];
      end
    end
  end

  logic [16:0] pos;

  always_ff @(posedge clk) begin
    if (en[ST_POS]) begin
      if (zero[ST_DIVN]) begin
        pos <= '0;
      end else if (one[ST_DIVN]) begin
        pos <= Q16_ONE;
      end else begin
        pos <= {1'b0, quo[ST_DIVN]};
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stop selection and table access
  // ---------------------------------------------------------------------
  logic [21:0]       t_scl;
  logic [5:0]        idx_raw;
  logic [5:0]        idx_lim;
  logic [5:0]        idx;
  logic [16:0]       frac;
  logic [ADDR_W-1:0] raddr0;
  logic [ADDR_W-1:0] raddr1;
  logic              tbl_we;
  logic [8:0]        slot_w;

  always_ff @(posedge clk) begin
    if (en[ST_SCL]) begin
      t_scl <= 22'(pos) * 22'(side[ST_POS].cnt - 5'd1);
    end
  end

  always_comb begin
    idx_raw = t_scl[21:16];
    idx_lim = 6'(side[ST_SCL].cnt - 5'd2);
    idx     = (idx_raw > idx_lim) ? idx_lim : idx_raw;
    frac    = 17'(t_scl - {idx, 16'h0000});
    raddr0  = (side[ST_SCL].mode == MODE_BLEND) ? ADDR_W'(idx) : '0;
    raddr1  = ADDR_W'(idx + 6'd1);
    slot_w  = 9'(side[ST_SCL].slot);
    tbl_we  = v[ST_SCL] && !side[ST_SCL].pix && en[ST_RAM] && (slot_w < 9'(MAX_STOPS));
  end

  logic [31:0] c0;
  logic [31:0] c1;

  lgpg_ram #(
    .WIDTH (32),
    .DEPTH (MAX_STOPS)
  ) u_stop_ram (
    .clk    (clk),
    .we     (tbl_we),
    .waddr  (ADDR_W'(side[ST_SCL].slot)),
    .wdata  (side[ST_SCL].rgba),
    .re     (en[ST_RAM]),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (c0),
    .rdata1 (c1)
  );

  logic [16:0] frac_r;
  mode_t       mode_r;
  logic [25:0] off_r;

  always_ff @(posedge clk) begin
    if (en[ST_RAM]) begin
      frac_r <= frac;
      mode_r <= side[ST_SCL].mode;
      off_r  <= side[ST_SCL].off;
    end
  end

  // ---------------------------------------------------------------------
  // Channel blend and output word
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en[NSTG]) begin
      byte_offset <= off_r;
      case (mode_r)
        MODE_WHITE: begin
          out_red   <= 8'hFF;
          out_green <= 8'hFF;
          out_blue  <= 8'hFF;
          out_alpha <= 8'hFF;
        end
        MODE_SOLID: begin
          out_red   <= c0[31:24];
          out_green <= c0[23:16];
          out_blue  <= c0[15:8];
          out_alpha <= c0[7:0];
        end
        default: begin
          out_red   <= lerp8(c0[31:24], c1[31:24], frac_r);
          out_green <= lerp8(c0[23:16], c1[23:16], frac_r);
          out_blue  <= lerp8(c0[15:8], c1[15:8], frac_r);
          out_alpha <= lerp8(c0[7:0], c1[7:0], frac_r);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_accept_when_drained: assert property (@(posedge clk) disable iff (rst)
    !v[NSTG] |-> !in_stall)
    else $error("input stalled with an empty output stage");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    v[ST_DIVN] && !zero[ST_DIVN] && !one[ST_DIVN] |-> rem[ST_DIVN] < den[ST_DIVN])
    else $error("divider remainder out of range");

  a_stop_pair: assert property (@(posedge clk) disable iff (rst)
    v[ST_SCL] && side[ST_SCL].pix && side[ST_SCL].mode == MODE_BLEND
    |-> (idx + 6'd1 < 6'(side[ST_SCL].cnt)) && (frac <= Q16_ONE))
    else $error("stop pair or fraction out of range");

endmodule

`default_nettype wire

// File: tb/sv/linear_gradient_pixel_generator_unit_tb.sv
`timescale 1ns / 1ps

module linear_gradient_pixel_generator_unit_tb;
  import lgpg_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [25:0] offset;
  } pixel_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = REQ_LOAD;
  logic [11:0] pixel_x = '0;
  logic [11:0] pixel_y = '0;
  logic [3:0]  stop_slot = '0;
  logic [31:0] stop_rgba = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [7:0]  out_alpha;
  logic [25:0] byte_offset;

  linear_gradient_pixel_generator_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .stop_slot(stop_slot),
    .stop_rgba(stop_rgba),
    .out_valid(out_valid), .out_stall(out_stall), .out_blue(out_blue),
    .out_green(out_green), .out_red(out_red), .out_alpha(out_alpha),
    .byte_offset(byte_offset)
  );

  always #1 clk = ~clk;

  // Shadow copy of the block's registers and stop table
  logic [12:0] width_q = 13'd256;
  logic [12:0] height_q = 13'd256;
  logic [15:0] dir_x_q = 16'd16384;
  logic [15:0] dir_y_q = 16'd0;
  logic [4:0]  stops_q = 5'd2;
  logic [31:0] stop_colors [16];

  pixel_word_t pending_pixels[$];
  int errors = 0;
  int cycles = 0;
  bit send_gaps = 1'b1;
  bit recv_stalls = 1'b1;
  int stall_hold = 0;

  function automatic logic [7:0] blend_byte(logic [7:0] a, logic [7:0] b, longint f);
    longint s;
    s = longint'(a) * (65536 - f) + longint'(b) * f;
    return s[23:16];
  endfunction

  // Expected pixel word for coordinates x, y under the current settings
  function automatic pixel_word_t shade_pixel(logic [11:0] x, logic [11:0] y);
    pixel_word_t pw;
    longint w, h, dx, dy, len, num, den, pos, t, idx, f, n;
    logic [31:0] c0, c1;
    w = (width_q == 0) ? 1 : longint'(width_q);
    h = (height_q == 0) ? 1 : longint'(height_q);
    n = (stops_q > 16) ? 16 : longint'(stops_q);
    dx = longint'(signed'(dir_x_q));
    dy = longint'(signed'(dir_y_q));
    if (n == 0) begin
      pw.blue = 8'hFF; pw.green = 8'hFF; pw.red = 8'hFF; pw.alpha = 8'hFF;
    end else if (n == 1) begin
      c0 = stop_colors[0];
      pw.red = c0[31:24]; pw.green = c0[23:16]; pw.blue = c0[15:8]; pw.alpha = c0[7:0];
    end else begin
      len = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
      if (len == 0) begin
        pos = 0;
      end else begin
        num = 2 * (longint'(x) * dx * h + longint'(y) * dy * w) + len * w * h;
        den = 2 * len * w * h;
        if (num <= 0) pos = 0;
        else if (num >= den) pos = 65536;
        else pos = (num * 65536) / den;
      end
      t = pos * (n - 1);
      idx = t >> 16;
      if (idx > n - 2) idx = n - 2;
      f = t - idx * 65536;
      c0 = stop_colors[idx];
      c1 = stop_colors[idx + 1];
      pw.red   = blend_byte(c0[31:24], c1[31:24], f);
      pw.green = blend_byte(c0[23:16], c1[23:16], f);
      pw.blue  = blend_byte(c0[15:8], c1[15:8], f);
      pw.alpha = blend_byte(c0[7:0], c1[7:0], f);
    end
    pw.offset = 26'((longint'(y) * w + longint'(x)) * 4);
    return pw;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request word and hold it until accepted
  task automatic send_word(logic kind, logic [11:0] x, logic [11:0] y,
                           logic [3:0] slot, logic [31:0] rgba);
    int gap;
    gap = send_gaps ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    req_type = kind;
    pixel_x = x;
    pixel_y = y;
    stop_slot = slot;
    stop_rgba = rgba;
    do @(posedge clk); while (in_stall);
    if (kind == REQ_LOAD) stop_colors[slot] = rgba;
    else pending_pixels.push_back(shade_pixel(x, y));
  endtask

  task automatic send_pixel(logic [11:0] x, logic [11:0] y);
    send_word(REQ_PIXEL, x, y, 4'($urandom()), $urandom());
  endtask

  task automatic send_stop(logic [3:0] slot, logic [31:0] rgba);
    send_word(REQ_LOAD, 12'($urandom()), 12'($urandom()), slot, rgba);
  endtask

  // Drop valid, wait for every pixel, then let trailing loads retire
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {index, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (index)
      REG_IMAGE_WIDTH:  width_q = value[12:0];
      REG_IMAGE_HEIGHT: height_q = value[12:0];
      REG_DIR_X:        dir_x_q = value[15:0];
      REG_DIR_Y:        dir_y_q = value[15:0];
      REG_STOP_COUNT:   stops_q = value[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [12:0] w, logic [12:0] h, logic [15:0] dx,
                            logic [15:0] dy, logic [4:0] n);
    write_reg(REG_IMAGE_WIDTH, 32'(w));
    write_reg(REG_IMAGE_HEIGHT, 32'(h));
    write_reg(REG_DIR_X, 32'(dx));
    write_reg(REG_DIR_Y, 32'(dy));
    write_reg(REG_STOP_COUNT, 32'(n));
  endtask

  // Fill the whole table first so no pixel ever reads an unwritten stop
  task automatic test_stop_table();
    send_stop(4'd0, 32'h0000_0000);
    send_stop(4'd1, 32'hFFFF_FFFF);
    for (int i = 2; i < 16; i++) send_stop(4'(i), $urandom());
    wait_idle();
  endtask

  // Corners, degenerate settings and out-of-image coordinates
  task automatic test_directed();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd255, 12'd255);
    send_pixel(12'd4095, 12'd4095);
    wait_idle();
    set_config(13'd4096, 13'd1, 16'hC000, 16'h4000, 5'd16);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd0);
    wait_idle();
    set_config(13'd0, 13'd0, 16'h8000, 16'h7FFF, 5'd31);
    send_pixel(12'd1, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    wait_idle();
    set_config(13'd8191, 13'd8191, 16'h0000, 16'h0000, 5'd5);
    send_pixel(12'd100, 12'd3000);
    wait_idle();
    write_reg(REG_STOP_COUNT, 32'd0);
    send_pixel(12'd7, 12'd9);
    wait_idle();
    write_reg(REG_STOP_COUNT, 32'd1);
    send_pixel(12'd7, 12'd9);
    send_stop(4'd0, 32'h1234_5678);
    send_pixel(12'd7, 12'd9);
    wait_idle();
  endtask

  // Random settings per phase, random mix of loads and pixels
  task automatic test_random();
    int r;
    for (int phase = 0; phase < 10; phase++) begin
      r = $urandom_range(0, 3);
      set_config(
        (r == 0) ? 13'd1 : (r == 1) ? 13'd4096 : 13'($urandom()),
        (r == 0) ? 13'd4096 : (r == 1) ? 13'd1 : 13'($urandom()),
        16'($urandom()), 16'($urandom()),
        (phase == 0) ? 5'd16 : (phase == 1) ? 5'd2 : 5'($urandom()));
      send_gaps = (phase % 4) != 3;
      recv_stalls = (phase % 5) != 4;
      for (int i = 0; i < 110; i++) begin
        if ($urandom_range(0, 99) < 15) send_stop(4'($urandom()), $urandom());
        else send_pixel(12'($urandom()), 12'($urandom()));
      end
      wait_idle();
    end
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
  endtask

  // Receiver stall pattern: mostly short bursts, a few long ones
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      automatic int r = $urandom_range(0, 99);
      if (!recv_stalls || r < 55) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(0, 15);
      end else if (r < 93) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end
    end
  end

  // Compare each accepted pixel word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel word off=%h", $time, byte_offset);
        errors++;
      end else begin
        automatic pixel_word_t want = pending_pixels.pop_front();
        if (out_blue !== want.blue) begin
          $display("%0t: blue expected %h actual %h", $time, want.blue, out_blue);
          errors++;
        end
        if (out_green !== want.green) begin
          $display("%0t: green expected %h actual %h", $time, want.green, out_green);
          errors++;
        end
        if (out_red !== want.red) begin
          $display("%0t: red expected %h actual %h", $time, want.red, out_red);
          errors++;
        end
        if (out_alpha !== want.alpha) begin
          $display("%0t: alpha expected %h actual %h", $time, want.alpha, out_alpha);
          errors++;
        end
        if (byte_offset !== want.offset) begin
          $display("%0t: byte_offset expected %h actual %h", $time, want.offset,
                   byte_offset);
          errors++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_stop_table();
    test_directed();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lgpg_pkg.sv
rtl/core/lgpg_ram.sv
rtl/core/linear_gradient_pixel_generator_unit.sv
tb/sv/linear_gradient_pixel_generator_unit_tb.sv
